// ===== hdl/qrb_pkg.sv =====
`timescale 1ns / 1ps
package qrb_pkg;

  // input quaternion component width, signed Q1.14
  localparam int QW = 16;
  // rotation matrix terms at scale 2^28
  localparam int TERM_W = 35;
  // sine of pitch when not clamped, |sp| < 2^28
  localparam int SP_W = 29;
  // square root datapath
  localparam int SQ_W = 58;
  localparam int ROOT_W = 29;
  localparam int SQRT_STEPS = 29;
  localparam int SQRT_TOP = 2 * (SQRT_STEPS - 1);
  // cordic vector and angle widths, angle at scale 2^30
  localparam int CW = 38;
  localparam int ZW = 34;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN = 24;
  // rounded angle before saturation
  localparam int RW = 18;

  localparam logic signed [TERM_W-1:0] ONE_Q28 = 35'sd268435456;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [RW-1:0] PI_Q13 = 18'sd25736;
  localparam logic signed [RW-1:0] HALF_PI_Q13 = 18'sd12868;

  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128
  };

  typedef struct packed {
    logic pos;
    logic neg;
  } qrb_clamp_t;

  // terms that ride along the square root pipeline
  typedef struct packed {
    logic signed [TERM_W-1:0] r21;
    logic signed [TERM_W-1:0] r22;
    logic signed [TERM_W-1:0] r10;
    logic signed [TERM_W-1:0] r00;
    logic signed [SP_W-1:0] sp;
    qrb_clamp_t clamp;
  } qrb_side_t;

  // round scale 2^30 to 2^13 and saturate to +-lim
  function automatic logic signed [RW-1:0] sat_angle(input logic signed [ZW-1:0] z,
                                                     input logic signed [RW-1:0] lim);
    logic signed [ZW:0] t;
    logic signed [RW-1:0] r;
    t = {z[ZW-1], z} + (ZW + 1)'(65536);
    r = t[ZW:17];
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

// ===== hdl/qrb_terms.sv =====
`timescale 1ns / 1ps
module qrb_terms import qrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] w,
  input  logic signed [QW-1:0] x,
  input  logic signed [QW-1:0] y,
  input  logic signed [QW-1:0] z,
  output logic                 out_valid,
  output logic [SQ_W-1:0]      sq,
  output qrb_side_t            side
);

  logic v1, v2;
  logic signed [2*QW-1:0] p_xz, p_wy, p_yz, p_wx, p_xx, p_yy, p_xy, p_wz, p_zz;
  logic signed [TERM_W-1:0] r20;
  logic signed [TERM_W-1:0] sp;
  qrb_side_t side_next;
  qrb_side_t side2;
  logic signed [2*SP_W-1:0] prod;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (en) begin
      p_xz <= x * z;
      p_wy <= w * y;
      p_yz <= y * z;
      p_wx <= w * x;
      p_xx <= x * x;
      p_yy <= y * y;
      p_xy <= x * y;
      p_wz <= w * z;
      p_zz <= z * z;
    end
  end

  // stage 2: matrix terms and pitch clamp
  always_comb begin
    r20 = (TERM_W'(p_xz) - TERM_W'(p_wy)) <<< 1;
    sp = -r20;
    side_next.r21 = (TERM_W'(p_yz) + TERM_W'(p_wx)) <<< 1;
    side_next.r22 = ONE_Q28 - ((TERM_W'(p_xx) + TERM_W'(p_yy)) <<< 1);
    side_next.r10 = (TERM_W'(p_xy) + TERM_W'(p_wz)) <<< 1;
    side_next.r00 = ONE_Q28 - ((TERM_W'(p_yy) + TERM_W'(p_zz)) <<< 1);
    side_next.sp = sp[SP_W-1:0];
    side_next.clamp.pos = (sp >= ONE_Q28);
    side_next.clamp.neg = (sp <= -ONE_Q28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side_next;
    end
  end

  // stage 3: square of the pitch sine
  assign prod = side2.sp * side2.sp;

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= prod;
      side <= side2;
    end
  end

  a_clamp_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(side.clamp.pos && side.clamp.neg))
    else $error("pitch clamped both ways");

endmodule

// ===== hdl/qrb_sqrt.sv =====
`timescale 1ns / 1ps
module qrb_sqrt import qrb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   sq,
  input  qrb_side_t         side_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output qrb_side_t         side_out
);

  logic [SQ_W-1:0] n_r   [SQRT_STEPS+1];
  logic [SQ_W-1:0] res_r [SQRT_STEPS+1];
  logic            v_r   [SQRT_STEPS+1];
  qrb_side_t       side_r [SQRT_STEPS+1];

  // entry: radicand 2^56 - sq
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= (SQ_W'(1) << SQRT_TOP) - sq;
      res_r[0] <= '0;
      side_r[0] <= side_in;
    end
  end

  // one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQRT_TOP - 2 * k);
    logic [SQ_W-1:0] sum;
    logic [SQ_W-1:0] n_next;
    logic [SQ_W-1:0] res_next;

    always_comb begin
      sum = res_r[k] + BIT;
      if (n_r[k] >= sum) begin
        n_next = n_r[k] - sum;
        res_next = (res_r[k] >> 1) + BIT;
      end else begin
        n_next = n_r[k];
        res_next = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1] <= n_next;
        res_r[k+1] <= res_next;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS];
  assign root = res_r[SQRT_STEPS][ROOT_W-1:0];
  assign side_out = side_r[SQRT_STEPS];

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !side_out.clamp.pos && !side_out.clamp.neg
    |-> res_r[SQRT_STEPS] <= (SQ_W'(1) << (SQRT_STEPS - 1)))
    else $error("square root above one");

endmodule

// ===== hdl/qrb_cordic.sv =====
`timescale 1ns / 1ps
module qrb_cordic import qrb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  input  qrb_clamp_t           flags_in,
  output logic                 out_valid,
  output logic signed [ZW-1:0] z_out,
  output qrb_clamp_t           flags_out
);

  logic signed [CW-1:0] x_r [CORDIC_ITERATIONS+1];
  logic signed [CW-1:0] y_r [CORDIC_ITERATIONS+1];
  logic signed [ZW-1:0] z_r [CORDIC_ITERATIONS+1];
  logic                 zero_r [CORDIC_ITERATIONS+1];
  logic                 v_r [CORDIC_ITERATIONS+1];
  qrb_clamp_t           flags_r [CORDIC_ITERATIONS+1];

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;

  // quarter turn into the right half plane
  always_comb begin
    x0 = x_in;
    y0 = y_in;
    z0 = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0 = y_in;
        y0 = -x_in;
        z0 = HALF_PI_Q30;
      end else begin
        x0 = -y_in;
        y0 = x_in;
        z0 = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0;
      y_r[0] <= y0;
      z_r[0] <= z0;
      zero_r[0] <= (x_in == 0) && (y_in == 0);
      flags_r[0] <= flags_in;
    end
  end

  // vectoring micro-rotations, one per stage
  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    logic signed [CW-1:0] x_next, y_next;
    logic signed [ZW-1:0] z_next;

    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (y_r[i] >= 0) begin
        x_next = x_r[i] + ys;
        y_next = y_r[i] - xs;
        z_next = z_r[i] + ATAN_Q30[i];
      end else begin
        x_next = x_r[i] - ys;
        y_next = y_r[i] + xs;
        z_next = z_r[i] - ATAN_Q30[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_next;
        y_r[i+1] <= y_next;
        z_r[i+1] <= z_next;
        zero_r[i+1] <= zero_r[i];
        flags_r[i+1] <= flags_r[i];
      end
    end
  end

  assign out_valid = v_r[CORDIC_ITERATIONS];
  assign z_out = zero_r[CORDIC_ITERATIONS] ? '0 : z_r[CORDIC_ITERATIONS];
  assign flags_out = flags_r[CORDIC_ITERATIONS];

endmodule

// ===== hdl/quaternion_to_roll_pitch_yaw.sv =====
`timescale 1ns / 1ps
// Quaternion to roll, pitch and yaw (Z-Y-X Euler angles).
// Input stream: one transfer per unit quaternion on s_tdata, four signed Q1.14
// components w, x, y, z. Output stream: one transfer per quaternion on m_tdata
// with roll and yaw in signed Q2.13 radians, pitch in Q1.13 clamped to +-pi/2.
// From input transfer to output valid, a result passes the stages that form
// the rotation matrix terms and the pitch sine squared, the bit-per-stage
// square root that gives the pitch cosine, the pipelined CORDIC (one
// quarter-turn stage plus 16 micro-rotations, three units side by side) and
// one output register for rounding and saturation.
// Throughput is one quaternion per cycle while the receiver takes results.
// The pipeline advances as a whole: when the output holds a result that the
// receiver does not take, every stage holds and s_tready drops; nothing is
// lost or repeated. Reset (rst, synchronous) clears all valid bits, so the
// block comes out of reset empty and ready.
module quaternion_to_roll_pitch_yaw import qrb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle, zero pad
);

  logic en;
  logic t_valid;
  logic [SQ_W-1:0] t_sq;
  qrb_side_t t_side;
  logic q_valid;
  logic [ROOT_W-1:0] q_root;
  qrb_side_t q_side;
  logic roll_valid, pitch_valid, yaw_valid;
  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
  qrb_clamp_t pitch_flags;
  logic signed [RW-1:0] roll_r, pitch_r, yaw_r;
  logic signed [RW-1:0] pitch_sel;

  // whole pipeline moves unless a result waits
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  qrb_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .w         (s_tdata[15:0]),
    .x         (s_tdata[31:16]),
    .y         (s_tdata[47:32]),
    .z         (s_tdata[63:48]),
    .out_valid (t_valid),
    .sq        (t_sq),
    .side      (t_side)
  );

  qrb_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_valid),
    .sq        (t_sq),
    .side_in   (t_side),
    .out_valid (q_valid),
    .root      (q_root),
    .side_out  (q_side)
  );

  qrb_cordic u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .y_in      (CW'(q_side.r21)),
    .x_in      (CW'(q_side.r22)),
    .flags_in  ('0),
    .out_valid (roll_valid),
    .z_out     (roll_z),
    .flags_out ()
  );

  qrb_cordic u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .y_in      (CW'(q_side.sp)),
    .x_in      (CW'(q_root)),
    .flags_in  (q_side.clamp),
    .out_valid (pitch_valid),
    .z_out     (pitch_z),
    .flags_out (pitch_flags)
  );

  qrb_cordic u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .y_in      (CW'(q_side.r10)),
    .x_in      (CW'(q_side.r00)),
    .flags_in  ('0),
    .out_valid (yaw_valid),
    .z_out     (yaw_z),
    .flags_out ()
  );

  // rounding, saturation and pitch clamp
  always_comb begin
    roll_r = sat_angle(roll_z, PI_Q13);
    yaw_r = sat_angle(yaw_z, PI_Q13);
    pitch_r = sat_angle(pitch_z, HALF_PI_Q13);
    if (pitch_flags.pos) begin
      pitch_sel = HALF_PI_Q13;
    end else if (pitch_flags.neg) begin
      pitch_sel = -HALF_PI_Q13;
    end else begin
      pitch_sel = pitch_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= roll_valid && pitch_valid && yaw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, yaw_r[15:0], pitch_sel[14:0], roll_r[15:0]};
    end
  end

  a_units_lockstep: assert property (@(posedge clk) disable iff (rst)
    (roll_valid == pitch_valid) && (pitch_valid == yaw_valid))
    else $error("cordic units out of step");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd12868)
              && ($signed(m_tdata[30:16]) >= -15'sd12868))
    else $error("pitch out of range");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

// ===== tb/tb_quaternion_to_roll_pitch_yaw.sv =====
`timescale 1ns / 1ps
module tb_quaternion_to_roll_pitch_yaw;
  import qrb_pkg::*;

  localparam int LATENCY = 51;
  localparam int RANDOM_QUATS = 1000;
  localparam int STALL_LIMIT = 5000;
  localparam int DIRECTED_ROWS = 20;
  localparam longint Q28 = 64'sd268435456;
  localparam longint HALF_PI_Z = 64'sd1686629713;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  // directed row: quaternion, and a typed expectation where one is obvious
  typedef struct {
    quat_t q;
    bit typed;
    euler_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;

  quaternion_to_roll_pitch_yaw dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_t angles_pending[$];
  row_t directed[DIRECTED_ROWS];
  int mismatches = 0;
  int quats_sent = 0;
  int angles_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit calm = 0;        // no idling near the end
  bit hold_sink = 0;   // long receiver hold-off
  bit timed_out = 0;

  // floor shift right for signed values
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring rotation, angle at scale 2^30
  function automatic longint vector_angle(longint yv, longint xv);
    longint ang, t, xs, ys;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; ang = HALF_PI_Z;
      end else begin
        xv = -yv; yv = t; ang = -HALF_PI_Z;
      end
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      xs = fshr(xv, i);
      ys = fshr(yv, i);
      if (yv >= 0) begin
        xv += ys; yv -= xs; ang += longint'(ATAN_Q30[i]);
      end else begin
        xv -= ys; yv += xs; ang -= longint'(ATAN_Q30[i]);
      end
    end
    return ang;
  endfunction

  function automatic longint round_angle(longint a, longint lim);
    longint r;
    r = fshr(a + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(quat_t q);
    longint w, x, y, z, r20, r21, r22, r10, r00, sp, c, p;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    r20 = 2 * (x * z - w * y);
    r21 = 2 * (y * z + w * x);
    r22 = Q28 - 2 * (x * x + y * y);
    r10 = 2 * (x * y + w * z);
    r00 = Q28 - 2 * (y * y + z * z);
    sp = -r20;
    if (sp >= Q28) p = 12868;
    else if (sp <= -Q28) p = -12868;
    else begin
      c = int_sqrt((64'd1 << 56) - longint'(sp * sp));
      p = round_angle(vector_angle(sp, c), 12868);
    end
    e.roll = 16'(round_angle(vector_angle(r21, r22), 25736));
    e.pitch = 15'(p);
    e.yaw = 16'(round_angle(vector_angle(r10, r00), 25736));
    return e;
  endfunction

  function automatic quat_t mk(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    return q;
  endfunction

  function automatic euler_t ea(int r, int p, int y);
    euler_t e;
    e.roll = 16'(r); e.pitch = 15'(p); e.yaw = 16'(y);
    return e;
  endfunction

  // random component, uniform in -16384 to 16384
  function automatic int rnd_comp();
    return $urandom_range(32768) - 16384;
  endfunction

  function automatic quat_t rnd_unit();
    real a, b, c, d, n;
    a = real'(rnd_comp()); b = real'(rnd_comp());
    c = real'(rnd_comp()); d = real'(rnd_comp());
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) return mk(16384, 0, 0, 0);
    return mk(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
              int'(c * 16384.0 / n), int'(d * 16384.0 / n));
  endfunction

  task automatic send_quat(quat_t q);
    s_tdata <= {q.z, q.y, q.x, q.w};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    quats_sent++;
    angles_pending.push_back(quat_to_euler(q));
    @(negedge clk);
    if (!calm && $urandom_range(7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
  endtask

  task automatic report(string what, int expv, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s on angle set %0d: expected %0d, got %0d",
               what, angles_seen, expv, got);
  endtask

  // directed table: identity, axis half turns, extremes, gimbal lock, zero
  initial begin
    directed[0]  = '{mk(16384, 0, 0, 0), 1, ea(0, 0, 0)};
    directed[1]  = '{mk(0, 0, 0, 0), 1, ea(0, 0, 0)};
    directed[2]  = '{mk(0, 16384, 0, 0), 0, ea(0, 0, 0)};
    directed[3]  = '{mk(0, 0, 16384, 0), 0, ea(0, 0, 0)};
    directed[4]  = '{mk(0, 0, 0, 16384), 0, ea(0, 0, 0)};
    directed[5]  = '{mk(11585, 0, 11585, 0), 0, ea(0, 0, 0)};
    directed[6]  = '{mk(11585, 0, -11585, 0), 0, ea(0, 0, 0)};
    directed[7]  = '{mk(16384, 16384, 16384, 16384), 0, ea(0, 0, 0)};
    directed[8]  = '{mk(-16384, -16384, -16384, -16384), 0, ea(0, 0, 0)};
    directed[9]  = '{mk(16384, -16384, 16384, -16384), 0, ea(0, 0, 0)};
    directed[10] = '{mk(-16384, 16384, -16384, 16384), 0, ea(0, 0, 0)};
    directed[11] = '{mk(11585, 11585, 0, 0), 0, ea(0, 0, 0)};
    directed[12] = '{mk(11585, 0, 0, -11585), 0, ea(0, 0, 0)};
    directed[13] = '{mk(8192, 8192, 8192, 8192), 0, ea(0, 0, 0)};
    directed[14] = '{mk(1, -1, 1, -1), 0, ea(0, 0, 0)};
    directed[15] = '{mk(0, 11585, 0, 11585), 0, ea(0, 0, 0)};
    directed[16] = '{mk(-16384, 0, 0, 0), 1, ea(0, 0, 0)};
    directed[17] = '{mk(16384, 0, 16384, 0), 0, ea(0, 0, 0)};
    directed[18] = '{mk(3000, -12000, 9000, -5000), 0, ea(0, 0, 0)};
    directed[19] = '{mk(-7000, 300, -15000, 2000), 0, ea(0, 0, 0)};
  end

  // stimulus
  initial begin
    quat_t q;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_quat(directed[i].q);
      if (directed[i].typed) begin
        angles_pending.pop_back();
        angles_pending.push_back(directed[i].e);
      end
    end
    for (int i = 0; i < RANDOM_QUATS; i++) begin
      // let the pipeline drain once mid-run
      if (i == 300) begin
        s_tvalid <= 1'b0;
        while (angles_pending.size() != 0) @(negedge clk);
      end
      if (i == 500) hold_sink = 1;
      if (i == 850) calm = 1;
      case ($urandom_range(9))
        0: q = mk(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
        1: q = mk($urandom, $urandom, $urandom, $urandom);
        default: q = rnd_unit();
      endcase
      send_quat(q);
    end
    s_tvalid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stalls, one long hold-off
  initial begin
    @(negedge clk);
    while (1) begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_sink = 0;
      end
      if (!calm && $urandom_range(5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // checker and watchdog
  always @(posedge clk) begin
    euler_t e;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (angles_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("angle set with none expected: %h", m_tdata);
        end else begin
          e = angles_pending.pop_front();
          if (m_tdata[15:0] !== e.roll) report("roll", e.roll, $signed(m_tdata[15:0]));
          if (m_tdata[30:16] !== e.pitch)
            report("pitch", e.pitch, $signed(m_tdata[30:16]));
          if (m_tdata[46:31] !== e.yaw) report("yaw", e.yaw, $signed(m_tdata[46:31]));
          if (m_tdata[47] !== 1'b0) report("pad", 0, m_tdata[47]);
        end
        angles_seen++;
      end
      if (idle_cycles >= STALL_LIMIT) timed_out = 1;
    end
  end

  // end of run
  initial begin
    wait (timed_out || (stim_done && angles_pending.size() == 0));
    if (!timed_out) repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d quaternions (directed, unit, raw and extreme) with %0d angle sets",
             quats_sent, angles_seen);
    if (timed_out) $display("no transfer for %0d cycles", STALL_LIMIT);
    if (!timed_out && mismatches == 0 && angles_pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== quaternion_to_roll_pitch_yaw.f =====
hdl/qrb_pkg.sv
hdl/qrb_terms.sv
hdl/qrb_sqrt.sv
hdl/qrb_cordic.sv
hdl/quaternion_to_roll_pitch_yaw.sv
tb/tb_quaternion_to_roll_pitch_yaw.sv
